@@ sv/fsd_pkg.sv @@
package fsd_pkg;

	// Default sizes of the line buffer and the error format
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int FRAC_BITS_DEF = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [3:0]  BITS_RST   = 4'd1;
	localparam logic [10:0] WIDTH_RST  = 11'd1024;
	localparam logic [15:0] HEIGHT_RST = 16'd1024;

	// One input pixel
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	// One dithered pixel
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       end_of_line;
		logic       end_of_frame;
	} pix_out_t;

	// Step enables from the controller to the datapath
	typedef struct packed {
		logic load;
		logic accum;
		logic scale;
		logic quant;
		logic form;
		logic recip;
		logic fix;
		logic err;
		logic diff;
		logic tail;
	} cmd_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic out_busy;
		logic tail_needed;
	} status_t;

endpackage

@@ sv/fsd_ctrl.sv @@
module fsd_ctrl import fsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_ACCUM = 10'b00_0000_0010,
		ST_SCALE = 10'b00_0000_0100,
		ST_QUANT = 10'b00_0000_1000,
		ST_FORM  = 10'b00_0001_0000,
		ST_RECIP = 10'b00_0010_0000,
		ST_FIX   = 10'b00_0100_0000,
		ST_ERR   = 10'b00_1000_0000,
		ST_DIFF  = 10'b01_0000_0000,
		ST_TAIL  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Take a request only between pixels
	assign pixel_stall = (state_q != ST_IDLE);

	// Decode step enables
	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && pixel_valid;
		cmd.accum = (state_q == ST_ACCUM);
		cmd.scale = (state_q == ST_SCALE);
		cmd.quant = (state_q == ST_QUANT);
		cmd.form  = (state_q == ST_FORM);
		cmd.recip = (state_q == ST_RECIP);
		cmd.fix   = (state_q == ST_FIX);
		cmd.err   = (state_q == ST_ERR);
		cmd.diff  = (state_q == ST_DIFF) && !status.out_busy;
		cmd.tail  = (state_q == ST_TAIL);
	end

	// Advance through the steps of one pixel
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pixel_valid) state_d = ST_ACCUM;
			end
			ST_ACCUM: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_QUANT;
			ST_QUANT: state_d = ST_FORM;
			ST_FORM:  state_d = ST_RECIP;
			ST_RECIP: state_d = ST_FIX;
			ST_FIX:   state_d = ST_ERR;
			ST_ERR:   state_d = ST_DIFF;
			ST_DIFF: begin
				// hold until the result register is free
				if (!status.out_busy) begin
					state_d = status.tail_needed ? ST_TAIL : ST_IDLE;
				end
			end
			ST_TAIL:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_ACCUM)
		else $error("accepted pixel did not start the accumulate step");

	a_tail_cause: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAIL |-> $past(state_q) == ST_DIFF && $past(status.tail_needed))
		else $error("line tail write without a row end");

	a_diff_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIFF && status.out_busy |=> state_q == ST_DIFF)
		else $error("left the diffuse step while the result was held");

endmodule

@@ sv/fsd_dp.sv @@
module fsd_dp import fsd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  pix_in_t               pixel,
	output pix_out_t              result,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Error format and intermediate widths
	localparam int EW  = 10 + FRAC_BITS;
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = (AW + 1 > 11) ? AW + 1 : 11;
	localparam int DW  = FRAC_BITS + 19;
	localparam int T1W = EW + 9;
	localparam int UW  = 17;
	localparam int LW  = 10;
	localparam int RK  = 26;
	localparam int TW2 = FRAC_BITS + 18;
	localparam int TW3 = 18;
	localparam int Q2W = FRAC_BITS + 17;
	localparam int Q3W = 17;
	localparam int RW  = Q2W + 1;

	// floor(u / 255) == (u * RECIP255) >> RK for u below 2^17
	localparam logic [18:0] RECIP255 = 19'd263173;

	localparam logic [T1W-1:0] T1_BIAS = T1W'(255) << FRAC_BITS;

	localparam logic signed [DW-1:0] EMAX_D = {{(DW-EW+1){1'b0}}, {(EW-1){1'b1}}};
	localparam logic signed [DW-1:0] EMIN_D = {{(DW-EW+1){1'b1}}, {(EW-1){1'b0}}};

	// Reciprocals of 2*(2^bits-1), indexed by bits-1
	localparam logic [TW2-1:0] M2_TAB [8] = '{
		TW2'((64'd1 << TW2) / 64'd2),   TW2'((64'd1 << TW2) / 64'd6),
		TW2'((64'd1 << TW2) / 64'd14),  TW2'((64'd1 << TW2) / 64'd30),
		TW2'((64'd1 << TW2) / 64'd62),  TW2'((64'd1 << TW2) / 64'd126),
		TW2'((64'd1 << TW2) / 64'd254), TW2'((64'd1 << TW2) / 64'd510)
	};
	localparam logic [TW3-1:0] M3_TAB [8] = '{
		TW3'((64'd1 << TW3) / 64'd2),   TW3'((64'd1 << TW3) / 64'd6),
		TW3'((64'd1 << TW3) / 64'd14),  TW3'((64'd1 << TW3) / 64'd30),
		TW3'((64'd1 << TW3) / 64'd62),  TW3'((64'd1 << TW3) / 64'd126),
		TW3'((64'd1 << TW3) / 64'd254), TW3'((64'd1 << TW3) / 64'd510)
	};

	function automatic logic signed [EW-1:0] sat_e(input logic signed [DW-1:0] x);
		logic signed [EW-1:0] r;
		if (x > EMAX_D) begin
			r = EMAX_D[EW-1:0];
		end else if (x < EMIN_D) begin
			r = EMIN_D[EW-1:0];
		end else begin
			r = x[EW-1:0];
		end
		return r;
	endfunction

	// round(e * k / 16), ties away from zero
	function automatic logic signed [EW-1:0] share(input logic signed [EW-1:0] e,
			input logic [2:0] k);
		logic [EW-1:0] mag;
		logic [EW+2:0] m;
		logic [EW-1:0] q;
		mag = e[EW-1] ? (~e + 1'b1) : e;
		m   = (EW+3)'(mag) * (EW+3)'(k) + (EW+3)'(8);
		q   = EW'(m >> 4);
		return e[EW-1] ? -$signed(q) : $signed(q);
	endfunction

	// Configuration registers
	logic [3:0]  bits_q;
	logic [10:0] width_q;
	logic [15:0] height_q;

	// Frame position and carried errors
	logic [AW-1:0]        col_q;
	logic [15:0]          row_q;
	logic signed [EW-1:0] rc_q   [3];
	logic signed [EW-1:0] pend_q [3];
	logic signed [EW-1:0] diag_q [3];

	// Per-pixel context
	logic [7:0]    px_q [3];
	logic [AW-1:0] x_q;
	logic          eol_q;
	logic          first_q;
	logic          last_q;
	logic [7:0]    lm1_q;
	logic [2:0]    bidx_q;

	// Line buffer of errors for the next row
	logic [3*EW-1:0] lbuf [MAX_WIDTH];
	logic [3*EW-1:0] rd_q;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [3*EW-1:0] wdata;

	// Step registers
	logic signed [EW-1:0] v_q     [3];
	logic [UW-1:0]        u_q     [3];
	logic [LW-1:0]        lmag_q  [3];
	logic [TW2-1:0]       t2_q    [3];
	logic [TW3-1:0]       t3_q    [3];
	logic [Q2W-1:0]       q2e_q   [3];
	logic [Q3W-1:0]       q3e_q   [3];
	logic signed [RW-1:0] recon_q [3];
	logic [7:0]           o_q     [3];
	logic signed [EW-1:0] e_q     [3];

	pix_out_t result_q;
	logic     result_valid_q;

	// Combinational intermediates
	logic [3:0]           b_eff;
	logic [7:0]           lm1_c;
	logic [WW-1:0]        w_ext;
	logic [WW-1:0]        w_eff;
	logic [WW-1:0]        xp1;
	logic [16:0]          h_eff;
	logic [16:0]          rp1;
	logic                 eol_c;
	logic                 last_c;
	logic [8:0]           dvs;
	logic signed [EW-1:0] below_w [3];
	logic signed [DW-1:0] pw_w    [3];
	logic signed [EW-1:0] v_d     [3];
	logic [EW-1:0]        vmag_w  [3];
	logic [EW+7:0]        p1_w    [3];
	logic [T1W-1:0]       t1_w    [3];
	logic [UW+18:0]       p2_w    [3];
	logic [TW3-1:0]       p510_w  [3];
	logic [2*TW2-1:0]     p3_w    [3];
	logic [2*TW3-1:0]     p4_w    [3];
	logic [TW2-1:0]       r2_w    [3];
	logic [TW3-1:0]       r3_w    [3];
	logic [Q2W-1:0]       q2_w    [3];
	logic [Q3W-1:0]       q3_w    [3];
	logic signed [EW-1:0] sh7_w   [3];
	logic signed [EW-1:0] sh5_w   [3];
	logic signed [EW-1:0] sh3_w   [3];
	logic signed [EW-1:0] sh1_w   [3];
	logic signed [EW-1:0] bw_w    [3];
	logic signed [EW-1:0] pnew_w  [3];

	// Clamp configuration and locate the pixel
	always_comb begin
		if (bits_q == 4'd0) begin
			b_eff = 4'd1;
		end else if (bits_q > 4'd8) begin
			b_eff = 4'd8;
		end else begin
			b_eff = bits_q;
		end
		lm1_c = 8'((9'd1 << b_eff) - 9'd1);

		w_ext = WW'(width_q);
		if (w_ext == '0) begin
			w_eff = WW'(1);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		xp1   = WW'(col_q) + WW'(1);
		eol_c = (xp1 >= w_eff);

		h_eff  = (height_q == 16'd0) ? 17'd1 : {1'b0, height_q};
		rp1    = {1'b0, row_q} + 17'd1;
		last_c = (rp1 >= h_eff);
	end

	assign dvs = {lm1_q, 1'b0};

	// Per-channel arithmetic
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			// corrected value
			below_w[c] = first_q ? '0 : $signed(rd_q[c*EW +: EW]);
			pw_w[c]    = {{(DW-8-FRAC_BITS){1'b0}}, px_q[c], {FRAC_BITS{1'b0}}};
			v_d[c]     = sat_e(pw_w[c] + DW'(rc_q[c]) + DW'(below_w[c]));

			// level = round(v * lm1 / (255 * 2^F))
			vmag_w[c] = v_q[c][EW-1] ? (~v_q[c] + 1'b1) : v_q[c];
			p1_w[c]   = (EW+8)'(vmag_w[c]) * (EW+8)'(lm1_q);
			t1_w[c]   = {p1_w[c], 1'b0} + T1_BIAS;
			p2_w[c]   = (UW+19)'(u_q[c]) * (UW+19)'(RECIP255);

			// numerators of the two rescale divisions
			p510_w[c] = TW3'(lmag_q[c]) * TW3'(510);

			// reciprocal estimates, low by at most one
			p3_w[c] = (2*TW2)'(t2_q[c]) * (2*TW2)'(M2_TAB[bidx_q]);
			p4_w[c] = (2*TW3)'(t3_q[c]) * (2*TW3)'(M3_TAB[bidx_q]);

			// correct the estimates
			r2_w[c] = t2_q[c] - TW2'(q2e_q[c]) * TW2'(dvs);
			r3_w[c] = t3_q[c] - TW3'(q3e_q[c]) * TW3'(dvs);
			q2_w[c] = (r2_w[c] >= TW2'(dvs)) ? q2e_q[c] + Q2W'(1) : q2e_q[c];
			q3_w[c] = (r3_w[c] >= TW3'(dvs)) ? q3e_q[c] + Q3W'(1) : q3e_q[c];

			// diffusion shares
			sh7_w[c]  = share(e_q[c], 3'd7);
			sh5_w[c]  = share(e_q[c], 3'd5);
			sh3_w[c]  = share(e_q[c], 3'd3);
			sh1_w[c]  = share(e_q[c], 3'd1);
			bw_w[c]   = sat_e(DW'(pend_q[c]) + DW'(sh3_w[c]));
			pnew_w[c] = sat_e(DW'(diag_q[c]) + DW'(sh5_w[c]));
		end
	end

	// Line buffer write port: down-left entry on diffuse, own column at row end
	always_comb begin
		we    = (cmd.diff && !last_q && (x_q != '0)) || cmd.tail;
		waddr = cmd.tail ? x_q : x_q - AW'(1);
		for (int c = 0; c < 3; c++) begin
			wdata[c*EW +: EW] = cmd.tail ? pend_q[c] : bw_w[c];
		end
	end

	always_ff @(posedge clk) begin
		if (we) lbuf[waddr] <= wdata;
		if (cmd.load) rd_q <= lbuf[col_q];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q   <= BITS_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BITS:   bits_q   <= cfg_data[3:0];
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Position, carries and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= '0;
			row_q          <= '0;
			result_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				rc_q[c]   <= '0;
				pend_q[c] <= '0;
				diag_q[c] <= '0;
			end
		end else begin
			if (cmd.diff) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			if (cmd.diff) begin
				if (eol_q) begin
					col_q <= '0;
					row_q <= last_q ? 16'd0 : 16'(row_q + 16'd1);
				end else begin
					col_q <= x_q + AW'(1);
				end
				for (int c = 0; c < 3; c++) begin
					rc_q[c]   <= eol_q ? '0 : sh7_w[c];
					pend_q[c] <= last_q ? '0 : pnew_w[c];
					diag_q[c] <= last_q ? '0 : sh1_w[c];
				end
			end else if (cmd.tail) begin
				// drop the carries that would leave the row
				for (int c = 0; c < 3; c++) begin
					pend_q[c] <= '0;
					diag_q[c] <= '0;
				end
			end
		end
	end

	// Step registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q[0] <= pixel.red_in;
			px_q[1] <= pixel.green_in;
			px_q[2] <= pixel.blue_in;
			x_q     <= col_q;
			eol_q   <= eol_c;
			first_q <= (row_q == 16'd0);
			last_q  <= last_c;
			lm1_q   <= lm1_c;
			bidx_q  <= 3'(b_eff - 4'd1);
		end
		for (int c = 0; c < 3; c++) begin
			if (cmd.accum) v_q[c] <= v_d[c];
			if (cmd.scale) u_q[c] <= t1_w[c][FRAC_BITS+1 +: UW];
			if (cmd.quant) lmag_q[c] <= p2_w[c][RK +: LW];
			if (cmd.form) begin
				t2_q[c] <= (TW2'(p510_w[c]) << FRAC_BITS) + TW2'(lm1_q);
				t3_q[c] <= p510_w[c] + TW3'(lm1_q);
			end
			if (cmd.recip) begin
				q2e_q[c] <= p3_w[c][TW2 +: Q2W];
				q3e_q[c] <= p4_w[c][TW3 +: Q3W];
			end
			if (cmd.fix) begin
				recon_q[c] <= v_q[c][EW-1] ? -$signed({1'b0, q2_w[c]})
				                           : $signed({1'b0, q2_w[c]});
				if (v_q[c][EW-1]) begin
					o_q[c] <= 8'd0;
				end else begin
					o_q[c] <= (q3_w[c] > Q3W'(255)) ? 8'd255 : q3_w[c][7:0];
				end
			end
			if (cmd.err) e_q[c] <= sat_e(DW'(v_q[c]) - DW'(recon_q[c]));
		end
		if (cmd.diff) begin
			result_q.red_out      <= o_q[0];
			result_q.green_out    <= o_q[1];
			result_q.blue_out     <= o_q[2];
			result_q.end_of_line  <= eol_q;
			result_q.end_of_frame <= eol_q && last_q;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	assign status.out_busy    = result_valid_q && result_stall;
	assign status.tail_needed = eol_q && !last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.diff |-> !(result_valid_q && result_stall))
		else $error("result overwritten while held");

	a_tail_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tail |-> eol_q && !last_q)
		else $error("line tail write outside a row end");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= AW'(MAX_WIDTH - 1))
		else $error("column counter beyond line buffer");

endmodule

@@ sv/floyd_steinberg_dither.sv @@
// A result becomes valid once its pixel has passed the accumulate, scale,
// quantize, form, reciprocal, fix, error and diffuse steps, the last of them
// waiting while the result register is held. A new pixel is taken only after
// the last is through, plus a tail write at a row end outside the last row.
// Reset: 1 bit per channel, 1024 pixels per row, 1024 rows, position and
// carried errors cleared; the line buffer is not cleared (first row skips it).
module floyd_steinberg_dither import fsd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pix_in_t               pixel,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	output pix_out_t              result,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// Registers take a write at any time
	assign cfg_ready = 1'b1;

	fsd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.status      (status),
		.cmd         (cmd)
	);

	fsd_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.pixel        (pixel),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

@@ test/floyd_steinberg_dither_test.sv @@
module floyd_steinberg_dither_test;
	import fsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     ERR_W         = 10 + FRAC_BITS_DEF;
	localparam longint ERR_HI        = (longint'(1) << (ERR_W - 1)) - 1;
	localparam longint ERR_LO        = -ERR_HI - 1;
	localparam int     LB_DEPTH      = MAX_WIDTH_DEF;
	localparam int     RANDOM_ITEMS  = 2000;
	localparam int     SETTLE_CYCLES = 16;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     CYCLE_LIMIT   = 800000;

	typedef logic signed [ERR_W-1:0] err_t;

	// Tracks the diffusion state and holds the dithered pixels still owed
	class dither_scoreboard;
		logic [3:0]  bits_reg;
		logic [10:0] width_reg;
		logic [15:0] height_reg;
		err_t        below_err [LB_DEPTH][3];
		bit          below_written [LB_DEPTH];
		err_t        carry_right [3];
		err_t        carry_below [3];
		err_t        carry_diag [3];
		logic [9:0]  col;
		logic [15:0] row;
		pix_out_t    expected_dither [$];
		int          mismatches;
		int          checked;
		int          row_ends;
		int          frame_ends;
		int          reg_writes;

		function new();
			bits_reg = BITS_RST;
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			for (int i = 0; i < LB_DEPTH; i++) begin
				below_written[i] = 1'b0;
				for (int c = 0; c < 3; c++)
					below_err[i][c] = '0;
			end
			for (int c = 0; c < 3; c++) begin
				carry_right[c] = '0;
				carry_below[c] = '0;
				carry_diag[c] = '0;
			end
			col = '0;
			row = '0;
		endfunction

		function int eff_bits();
			if (bits_reg < 1) return 1;
			if (bits_reg > 8) return 8;
			return int'(bits_reg);
		endfunction

		function int eff_width(logic [10:0] w);
			if (w < 1) return 1;
			if (w > LB_DEPTH) return LB_DEPTH;
			return int'(w);
		endfunction

		function int eff_height(logic [15:0] h);
			return (h == 0) ? 1 : int'(h);
		endfunction

		function bit at_frame_start();
			return col == 0 && row == 0;
		endfunction

		// True when every line buffer entry below w has been filled since reset
		function bit lines_covered(int w);
			for (int i = 0; i < w; i++)
				if (!below_written[i]) return 1'b0;
			return 1'b1;
		endfunction

		// Divide rounding to nearest, ties away from zero
		function longint round_div(longint num, longint den);
			longint mag;
			longint q;
			mag = (num < 0) ? -num : num;
			q = (2 * mag + den) / (2 * den);
			return (num < 0) ? -q : q;
		endfunction

		function longint clip(longint v);
			if (v > ERR_HI) return ERR_HI;
			if (v < ERR_LO) return ERR_LO;
			return v;
		endfunction

		function int pending();
			return expected_dither.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BITS:   bits_reg = data[3:0];
				REG_WIDTH:  width_reg = data[10:0];
				REG_HEIGHT: height_reg = data;
				default: ;
			endcase
			reg_writes++;
		endfunction

		// Quantize one pixel, diffuse its error and queue the dithered result
		function void note_pixel(pix_in_t p);
			logic [7:0] chan [3];
			logic [7:0] dith [3];
			int         x;
			int         width;
			int         height;
			bit         eol;
			bit         eof;
			bit         first_row;
			bit         last_row;
			longint     lm1;
			longint     below;
			longint     v;
			longint     level;
			longint     recon;
			longint     e;
			longint     o;
			pix_out_t   r;
			chan[0] = p.red_in;
			chan[1] = p.green_in;
			chan[2] = p.blue_in;
			width = eff_width(width_reg);
			height = eff_height(height_reg);
			lm1 = (longint'(1) << eff_bits()) - 1;
			x = int'(col);
			if (x >= LB_DEPTH) x = LB_DEPTH - 1;
			eol = (x + 1 >= width);
			first_row = (row == 0);
			last_row = (int'(row) + 1 >= height);
			eof = eol && last_row;
			for (int c = 0; c < 3; c++) begin
				below = first_row ? 0 : longint'(below_err[x][c]);
				v = clip(longint'(chan[c]) * 256 + longint'(carry_right[c]) + below);
				level = round_div(v * lm1, 255 * 256);
				recon = round_div(level * 255 * 256, lm1);
				e = clip(v - recon);
				o = round_div(level * 255, lm1);
				if (o < 0) o = 0;
				if (o > 255) o = 255;
				dith[c] = o[7:0];
				carry_right[c] = eol ? '0 : err_t'(round_div(e * 7, 16));
				if (!last_row) begin
					if (x > 0) begin
						below_err[x-1][c] = err_t'(clip(longint'(carry_below[c]) +
							round_div(e * 3, 16)));
						below_written[x-1] = 1'b1;
					end
					carry_below[c] = err_t'(clip(longint'(carry_diag[c]) + round_div(e * 5, 16)));
					carry_diag[c] = err_t'(round_div(e, 16));
					if (eol) begin
						below_err[x][c] = carry_below[c];
						below_written[x] = 1'b1;
						carry_below[c] = '0;
						carry_diag[c] = '0;
					end
				end else begin
					carry_below[c] = '0;
					carry_diag[c] = '0;
				end
			end
			r.red_out = dith[0];
			r.green_out = dith[1];
			r.blue_out = dith[2];
			r.end_of_line = eol;
			r.end_of_frame = eof;
			expected_dither.push_back(r);
			// advance the frame position
			if (eol) begin
				col = '0;
				row = eof ? 16'd0 : row + 16'd1;
			end else begin
				col = 10'(x + 1);
			end
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("pixel %0d %s: got %0h, expected %0h", checked, name, got, want));
		endtask

		task check_pixel(pix_out_t got);
			pix_out_t want;
			if (expected_dither.size() == 0) begin
				report($sformatf("result %0h with no pixel request pending", got));
				return;
			end
			want = expected_dither.pop_front();
			compare_field("red_out", got.red_out, want.red_out);
			compare_field("green_out", got.green_out, want.green_out);
			compare_field("blue_out", got.blue_out, want.blue_out);
			compare_field("end_of_line", 8'(got.end_of_line), 8'(want.end_of_line));
			compare_field("end_of_frame", 8'(got.end_of_frame), 8'(want.end_of_frame));
			if (want.end_of_line) row_ends++;
			if (want.end_of_frame) frame_ends++;
			checked++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	pix_in_t               pixel = '0;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_stall;
	pix_out_t              result;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit               calm = 1'b0;
	bit               hold_req = 1'b0;
	int               cycles = 0;
	dither_scoreboard sb;

	floyd_steinberg_dither u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Stall the result side at random; hold off once for a long stretch
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= !calm && ($urandom_range(99, 0) < 38);
		end
	end

	// Note accepted requests and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (pixel_valid && !pixel_stall) sb.note_pixel(pixel);
			if (result_valid && !result_stall) sb.check_pixel(result);
		end
	end

	// End the run as a failure once the cycle limit is reached
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d pixels still owed", cycles, sb.pending());
		$display("status: fail");
		$finish;
	end

	// Offer one pixel request, idling first at random, and wait for it to go in
	task automatic send_pixel(input pix_in_t p);
		while (!calm && $urandom_range(99, 0) < 38) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and wait until every owed pixel is back and the block is quiet
	task automatic settle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [10:0] pick_width();
		case ($urandom_range(19, 0))
			0: return 11'd0;
			1: return 11'd1;
			2: return 11'd2047;
			3: return 11'd1024;
			4: return 11'($urandom_range(2046, 1025));
			5: return 11'($urandom_range(1023, 17));
			default: return 11'($urandom_range(16, 2));
		endcase
	endfunction

	function automatic logic [15:0] pick_height();
		case ($urandom_range(15, 0))
			0: return 16'd0;
			1: return 16'd65535;
			2: return 16'($urandom_range(65534, 9));
			default: return 16'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic pix_in_t random_pixel();
		pix_in_t p;
		p = pix_in_t'(24'($urandom));
		case ($urandom_range(9, 0))
			0: p = '0;
			1: p = '1;
			2: begin
				p.red_in = p.red_in[0] ? 8'hFF : 8'h00;
				p.green_in = p.green_in[0] ? 8'hFF : 8'h00;
				p.blue_in = p.blue_in[0] ? 8'hFF : 8'h00;
			end
			default: ;
		endcase
		return p;
	endfunction

	// Pick new settings; never let the line buffer be read where it was not filled
	task automatic reconfigure();
		logic [3:0]  b;
		logic [10:0] w;
		logic [15:0] h;
		bit          do_b;
		bit          do_w;
		bit          do_h;
		b = 4'($urandom_range(15, 0));
		do_b = 1'($urandom_range(1, 0));
		do_w = 1'($urandom_range(1, 0));
		do_h = 1'($urandom_range(1, 0));
		w = do_w ? pick_width() : sb.width_reg;
		h = do_h ? pick_height() : sb.height_reg;
		if (!sb.at_frame_start() && !sb.lines_covered(sb.eff_width(w))) begin
			// mid-frame over unfilled lines: only shrink
			if (do_w) w = 11'($urandom_range(sb.eff_width(sb.width_reg), 0));
			if (do_h) h = 16'($urandom_range(sb.eff_height(sb.height_reg), 0));
		end
		if (do_b) write_reg(REG_BITS, {12'($urandom), b});
		if (do_w) write_reg(REG_WIDTH, {5'($urandom), w});
		if (do_h) write_reg(REG_HEIGHT, h);
	endtask

	initial begin
		int sent;
		int n;
		bit held;
		held = 1'b0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start-up settings: one bit per channel, full-length rows
		send_pixel({8'h00, 8'h00, 8'h00});
		send_pixel({8'hFF, 8'hFF, 8'hFF});
		send_pixel({8'h80, 8'h7F, 8'h01});
		send_pixel({8'hFE, 8'h00, 8'hFF});
		// shrink the row under the column count: the next pixel ends the row
		settle();
		write_reg(REG_WIDTH, 16'd3);
		send_pixel({8'h40, 8'hC0, 8'h80});
		// shrink the frame so the current row is the last; full eight bits
		settle();
		write_reg(REG_BITS, 16'd8);
		write_reg(REG_HEIGHT, 16'd2);
		send_pixel({8'hFF, 8'h00, 8'h80});
		send_pixel({8'h01, 8'hFE, 8'h7F});
		send_pixel({8'hFF, 8'hFF, 8'hFF});
		// zero settings act as one: every pixel ends its row and frame
		settle();
		write_reg(REG_BITS, 16'd0);
		write_reg(REG_WIDTH, 16'd0);
		write_reg(REG_HEIGHT, 16'd0);
		send_pixel({8'hFF, 8'h80, 8'h00});
		send_pixel({8'h7F, 8'h7F, 8'h7F});
		// bits above eight clamp; a small 4x3 frame
		settle();
		write_reg(REG_BITS, 16'd15);
		write_reg(REG_WIDTH, 16'd4);
		write_reg(REG_HEIGHT, 16'd3);
		for (int i = 0; i < 12; i++)
			send_pixel({8'(i * 37), 8'(255 - i * 21), (i % 2 == 1) ? 8'hFF : 8'h00});

		// random settings and pixels
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			reconfigure();
			n = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 60) : $urandom_range(60, 4);
			if (!held && sent >= 400) begin
				hold_req = 1'b1;
				held = 1'b1;
				n = 150;
			end
			repeat (n) begin
				calm = (sent >= 1000 && sent < 1300);
				send_pixel(random_pixel());
				sent++;
			end
		end
		calm = 1'b0;
		settle();
		repeat (40) @(posedge clk);

		$display("checked %0d dithered pixels with %0d row ends and %0d frame ends",
			sb.checked, sb.row_ends, sb.frame_ends);
		$display("%0d register writes, mid-frame shrinks and one long result hold-off",
			sb.reg_writes);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/fsd_pkg.sv
sv/fsd_ctrl.sv
sv/fsd_dp.sv
sv/floyd_steinberg_dither.sv
test/floyd_steinberg_dither_test.sv
